>>> rtl/core/resp_command_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command parser
// Concurrent property wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RESP_COMMAND_PARSER_ASSERT_SVH
`define RESP_COMMAND_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define RCP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("resp_command_parser: assertion failed");

// antecedent implies consequent in the next cycle
`define RCP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("resp_command_parser: assertion failed");

`else

`define RCP_ASSERT_IMP(label, clk, rst, ante, cons)
`define RCP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/rcp_pkg.sv
// ---------------------------------------------------------------------------
// Command parser package
// Phase codes, result kinds, error codes and byte constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcp_pkg;

   localparam int NUMBER_WIDTH_DEF = 64;

   // parser phase
   typedef enum logic [3:0] {
      PH_STAR     = 4'd0,
      PH_COUNT    = 4'd1,
      PH_COUNT_LF = 4'd2,
      PH_DOLLAR   = 4'd3,
      PH_LEN      = 4'd4,
      PH_LEN_LF   = 4'd5,
      PH_PAYLOAD  = 4'd6,
      PH_CR       = 4'd7,
      PH_LF       = 4'd8,
      PH_HUNT     = 4'd9
   } phase_type;

   // result kinds
   localparam logic [1:0] K_NAME = 2'd0;
   localparam logic [1:0] K_ARG  = 2'd1;
   localparam logic [1:0] K_END  = 2'd2;
   localparam logic [1:0] K_ERR  = 2'd3;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_NO_STAR   = 4'd1;
   localparam logic [3:0] ERR_NO_DOLLAR = 4'd2;
   localparam logic [3:0] ERR_NON_DIGIT = 4'd3;
   localparam logic [3:0] ERR_NO_LF     = 4'd4;
   localparam logic [3:0] ERR_EMPTY_NUM = 4'd5;
   localparam logic [3:0] ERR_OVERFLOW  = 4'd6;
   localparam logic [3:0] ERR_ZERO_CNT  = 4'd7;
   localparam logic [3:0] ERR_EMPTY_NAME= 4'd8;
   localparam logic [3:0] ERR_NO_CRLF   = 4'd9;

   // protocol bytes
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // one parser result
   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       command_done;
      logic [3:0] error_code;
   } result_type;

   // parser status seen by the top level
   typedef struct packed {
      phase_type phase;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/rcp_parser.sv
// ---------------------------------------------------------------------------
// Command parser state machine
// Consumes one byte per enable and produces at most one result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcp_parser
   import rcp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       enable,
   input  wire logic [7:0] byte_in,
   output result_type      result,
   output status_type      status
);

   localparam int NW = NUMBER_WIDTH;

   phase_type         phase_ff, phase_in;
   logic [NW-1:0]     acc_ff, acc_in;
   logic              saw_digit_ff, saw_digit_in;
   logic [NW-1:0]     elements_left_ff, elements_left_in;
   logic [NW-1:0]     bytes_left_ff, bytes_left_in;
   logic              in_name_ff, in_name_in;
   logic              empty_ff, empty_in;

   logic [7:0]        digit_diff;
   logic [NW+3:0]     acc_times_ten;
   logic              is_digit;
   logic              overflow;
   logic [7:0]        upper_byte;

   // scale the accumulator by ten and add the digit, one wide add
   assign digit_diff    = byte_in - CH_ZERO;
   assign is_digit      = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                        + {{NW{1'b0}}, digit_diff[3:0]};
   assign overflow      = |acc_times_ten[NW+3:NW];
   assign upper_byte    = ((byte_in >= CH_LOWER_A) && (byte_in <= CH_LOWER_Z)) ?
                          (byte_in - CASE_DELTA) : byte_in;

   // next state and result for the current byte
   always_comb begin
      phase_in         = phase_ff;
      acc_in           = acc_ff;
      saw_digit_in     = saw_digit_ff;
      elements_left_in = elements_left_ff;
      bytes_left_in    = bytes_left_ff;
      in_name_in       = in_name_ff;
      empty_in         = empty_ff;
      result           = '0;

      unique case (phase_ff)
         PH_STAR: begin
            if (byte_in != CH_STAR) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_STAR;
            end else begin
               acc_in       = '0;
               saw_digit_in = 1'b0;
               phase_in     = PH_COUNT;
            end
         end
         PH_HUNT: begin
            if (byte_in == CH_STAR) begin
               acc_in       = '0;
               saw_digit_in = 1'b0;
               phase_in     = PH_COUNT;
            end
         end
         PH_COUNT, PH_LEN: begin
            priority if (byte_in == CH_CR) begin
               phase_in = (phase_ff == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
            end else if (!is_digit) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NON_DIGIT;
            end else if (overflow) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_OVERFLOW;
            end else begin
               acc_in       = acc_times_ten[NW-1:0];
               saw_digit_in = 1'b1;
            end
         end
         PH_COUNT_LF: begin
            priority if (byte_in != CH_LF) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_LF;
            end else if (!saw_digit_ff) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_EMPTY_NUM;
            end else if (acc_ff == '0) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_ZERO_CNT;
            end else begin
               elements_left_in = acc_ff;
               in_name_in       = 1'b1;
               phase_in         = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (byte_in != CH_DOLLAR) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_DOLLAR;
            end else begin
               acc_in       = '0;
               saw_digit_in = 1'b0;
               phase_in     = PH_LEN;
            end
         end
         PH_LEN_LF: begin
            priority if (byte_in != CH_LF) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_LF;
            end else if (!saw_digit_ff) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_EMPTY_NUM;
            end else begin
               bytes_left_in = acc_ff;
               empty_in      = (acc_ff == '0);
               phase_in      = (acc_ff == '0) ? PH_CR : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in = bytes_left_ff - {{(NW-1){1'b0}}, 1'b1};
            if (bytes_left_ff == {{(NW-1){1'b0}}, 1'b1}) begin
               phase_in = PH_CR;
            end
            result.valid = 1'b1;
            if (in_name_ff) begin
               result.kind      = K_NAME;
               result.data_byte = upper_byte;
            end else begin
               result.kind      = K_ARG;
               result.data_byte = byte_in;
            end
         end
         PH_CR: begin
            if (byte_in != CH_CR) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_CRLF;
            end else begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            priority if (byte_in != CH_LF) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_CRLF;
            end else if (in_name_ff && empty_ff) begin
               phase_in          = PH_HUNT;
               result.valid      = 1'b1;
               result.kind       = K_ERR;
               result.error_code = ERR_EMPTY_NAME;
            end else begin
               in_name_in       = 1'b0;
               elements_left_in = elements_left_ff - {{(NW-1){1'b0}}, 1'b1};
               result.valid     = 1'b1;
               result.kind      = K_END;
               if (elements_left_ff == {{(NW-1){1'b0}}, 1'b1}) begin
                  phase_in            = PH_STAR;
                  result.command_done = 1'b1;
               end else begin
                  phase_in = PH_DOLLAR;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // advance parser state on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STAR;
         acc_ff           <= '0;
         saw_digit_ff     <= 1'b0;
         elements_left_ff <= '0;
         bytes_left_ff    <= '0;
         in_name_ff       <= 1'b0;
         empty_ff         <= 1'b0;
      end else if (enable) begin
         phase_ff         <= phase_in;
         acc_ff           <= acc_in;
         saw_digit_ff     <= saw_digit_in;
         elements_left_ff <= elements_left_in;
         bytes_left_ff    <= bytes_left_in;
         in_name_ff       <= in_name_in;
         empty_ff         <= empty_in;
      end
   end

   assign status.phase = phase_ff;

endmodule

`default_nettype wire

>>> rtl/core/resp_command_parser.sv
// ---------------------------------------------------------------------------
// Command request parser, top level
// Parses an array of bulk strings byte by byte into name, argument,
// element-end and error items.
// ---------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  req_byte_in[7:0]
//   rsp_      out         rsp_valid/rsp_stall  kind, data_byte, command_done,
//                                              error_code
//
// One byte per cycle while rsp_ does not stall; a byte's item passes the input
// register, then the parser logic into the result register.
// Reset is synchronous and returns the parser to waiting for an array marker.
// A stall on rsp_ holds the result register and the input register; req_stall
// rises only when both are full and the result is not being taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resp_command_parser_assert.svh"

module resp_command_parser
   import rcp_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_command_done,
   output logic [3:0]      rsp_error_code
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   logic        out_free;
   logic        advance;
   result_type  result;
   status_type  status;

   // advance the input item when the result register can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // hold the input item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_byte_in;
      end
   end

   rcp_parser #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .byte_in (in_byte_ff),
      .result  (result),
      .status  (status)
   );

   // load or drop the result item
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_command_done = out_ff.command_done;
   assign rsp_error_code   = out_ff.error_code;

   // error codes appear only on error items
   `RCP_ASSERT_IMP(a_code_on_error, clock, reset, rsp_valid && (rsp_kind != K_ERR), rsp_error_code == ERR_NONE)

   // command completion is flagged only on an element end
   `RCP_ASSERT_IMP(a_done_on_end, clock, reset, rsp_valid && rsp_command_done, rsp_kind == K_END)

   // an emitted error sends the parser hunting for a new request
   `RCP_ASSERT_NXT(a_error_hunts, clock, reset, advance && result.valid && (result.kind == K_ERR), status.phase == PH_HUNT)

   // a completed command returns the parser to request start
   `RCP_ASSERT_NXT(a_done_restarts, clock, reset, advance && result.valid && result.command_done, status.phase == PH_STAR)

endmodule

`default_nettype wire
